### hw/rtl/hvn_pkg.sv
// Shared types and constants of the hashed 3D value-noise unit.
package hvn_pkg;

    localparam int GRID_SIDE = 1024;
    localparam int IDX_W     = $clog2(GRID_SIDE);
    localparam int FRAC_BITS = 16;
    localparam int CELL_BITS = 8;
    // hash bits needed for the low 10 bits after the xor-shift by 13
    localparam int HASH_BITS = 23;
    localparam int HASH_OUT  = 10;

    localparam logic [31:0] HASH_MUL_A = 32'd374761393;
    localparam logic [31:0] HASH_MUL_B = 32'd668265263;
    localparam logic [31:0] HASH_MUL_C = 32'd2246822519;
    localparam logic [31:0] HASH_MUL_F = 32'd1274126177;

    localparam logic [31:0] ORIGIN_RESET  = 32'd0;
    localparam logic [31:0] SPACING_RESET = 32'd65536;
    localparam logic [31:0] SEED_RESET    = 32'd0;

    localparam logic [20:0] FADE_C6  = 21'd6;
    localparam logic [20:0] FADE_C15 = 21'd15;
    localparam logic [20:0] FADE_C10 = 21'd655360;

    typedef logic [31:0]            word_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CELL_BITS-1:0]   cell_t;
    typedef logic [15:0]            frac_t;
    typedef logic [16:0]            weight_t;
    typedef logic [HASH_BITS-1:0]   hash_t;
    typedef logic signed [16:0]     noise_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_SPACING_X = 3'd3,
        REG_SPACING_Y = 3'd4,
        REG_SPACING_Z = 3'd5,
        REG_SEED      = 3'd6
    } cfg_reg_t;

endpackage

### hw/rtl/hvn_axis.sv
// One axis: position, cell split, partial corner hashes and quintic fade weight.
module hvn_axis (
    input  logic             clk,
    input  logic             en,
    input  hvn_pkg::idx_t    g,
    input  hvn_pkg::word_t   origin,
    input  hvn_pkg::word_t   spacing,
    input  hvn_pkg::word_t   hash_mul,
    output hvn_pkg::hash_t   m0,
    output hvn_pkg::hash_t   m1,
    output hvn_pkg::weight_t weight
);
    import hvn_pkg::*;

    word_t   prod_reg;
    cell_t   cell_reg;
    frac_t   frac_reg;
    hash_t   m0_reg, m1_reg;
    frac_t   t3_reg, sq_reg;
    frac_t   cube_reg;
    logic [19:0] inner_reg;
    weight_t weight_reg;

    word_t       prod_next, pos;
    frac_t       frac_next;
    logic [8:0]  cell_lo, cell_hi;
    word_t       m0_full, m1_full;
    logic [31:0] sq_full, cube_full;
    logic [20:0] inner_full;
    logic [35:0] weight_full;

    // stage 1: index times spacing, low 32 bits
    assign prod_next = word_t'(g) * spacing;

    // stage 2: position, cell, fraction rescaled to Q0.16
    assign pos = origin + prod_reg;

    if (FRAC_BITS >= 16) begin : g_frac_wide
        assign frac_next = pos[FRAC_BITS-1 -: 16];
    end else begin : g_frac_narrow
        assign frac_next = {pos[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    end

    // stage 3: near/far corner hash terms, fraction squared
    assign cell_lo = {1'b0, cell_reg};
    assign cell_hi = cell_lo + 9'd1;
    assign m0_full = word_t'(cell_lo) * hash_mul;
    assign m1_full = word_t'(cell_hi) * hash_mul;
    assign sq_full = 32'(frac_reg) * 32'(frac_reg);

    // stage 4: cube and inner polynomial (always positive)
    assign cube_full  = 32'(sq_reg) * 32'(t3_reg);
    assign inner_full = FADE_C6 * 21'(sq_reg) + FADE_C10 - FADE_C15 * 21'(t3_reg);

    // stage 5: weight
    assign weight_full = 36'(cube_reg) * 36'(inner_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            cell_reg   <= pos[FRAC_BITS +: CELL_BITS];
            frac_reg   <= frac_next;
            m0_reg     <= m0_full[HASH_BITS-1:0];
            m1_reg     <= m1_full[HASH_BITS-1:0];
            t3_reg     <= frac_reg;
            sq_reg     <= sq_full[31:16];
            cube_reg   <= cube_full[31:16];
            inner_reg  <= inner_full[19:0];
            weight_reg <= weight_full[32:16];
        end
    end

    assign m0     = m0_reg;
    assign m1     = m1_reg;
    assign weight = weight_reg;

endmodule

### hw/rtl/hvn_corner.sv
// Eight corner hashes finished and centered to Q.16, plus one alignment stage.
module hvn_corner (
    input  logic            clk,
    input  logic            en,
    input  hvn_pkg::word_t  seed,
    input  hvn_pkg::hash_t  mx0,
    input  hvn_pkg::hash_t  mx1,
    input  hvn_pkg::hash_t  my0,
    input  hvn_pkg::hash_t  my1,
    input  hvn_pkg::hash_t  mz0,
    input  hvn_pkg::hash_t  mz1,
    output hvn_pkg::noise_t corner [8]
);
    import hvn_pkg::*;

    localparam logic [HASH_OUT-1:0] MUL_F_LO = HASH_MUL_F[HASH_OUT-1:0];

    noise_t corner_reg [8];
    noise_t corner_d_reg [8];
    noise_t corner_next [8];

    // corner k: bit 0 picks x, bit 1 picks y, bit 2 picks z
    always_comb
    begin
        hash_t               h;
        logic [HASH_OUT-1:0] mix;
        logic [HASH_OUT-1:0] hv;
        for (int k = 0; k < 8; k++)
        begin
            h = seed[HASH_BITS-1:0]
                ^ (k[0] ? mx1 : mx0)
                ^ (k[1] ? my1 : my0)
                ^ (k[2] ? mz1 : mz0);
            // low bits of (h ^ h >> 13) * F need only low bits of each factor
            mix = h[HASH_OUT-1:0] ^ h[13 +: HASH_OUT];
            hv  = mix * MUL_F_LO;
            // (hv - 512) * 128
            corner_next[k] = {~hv[HASH_OUT-1], hv[HASH_OUT-2:0], 7'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 8; k++)
            begin
                corner_reg[k]   <= corner_next[k];
                corner_d_reg[k] <= corner_reg[k];
            end
        end
    end

    assign corner = corner_d_reg;

endmodule

### hw/rtl/hvn_lerp.sv
// Two-stage lerp a + floor(w * (b - a) / 2^16).
module hvn_lerp (
    input  logic             clk,
    input  logic             en,
    input  hvn_pkg::noise_t  a,
    input  hvn_pkg::noise_t  b,
    input  hvn_pkg::weight_t w,
    output hvn_pkg::noise_t  res
);
    import hvn_pkg::*;

    noise_t             a_reg;
    logic signed [35:0] prod_reg;
    noise_t             res_reg;

    logic signed [17:0] diff;
    logic signed [17:0] w_s;
    logic signed [35:0] prod_next;
    logic signed [19:0] step;
    logic signed [19:0] sum;

    assign diff      = {b[16], b} - {a[16], a};
    assign w_s       = {1'b0, w};
    assign prod_next = diff * w_s;

    // arithmetic shift floors; the sum stays between a and b
    assign step = prod_reg[35:16];
    assign sum  = {{3{a_reg[16]}}, a_reg} + step;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a;
            prod_reg <= prod_next;
            res_reg  <= sum[16:0];
        end
    end

    assign res = res_reg;

endmodule

### hw/rtl/hashed_value_noise_3d_unit.sv
// Top level of the hashed 3D value-noise unit.
// One grid point (grid_ix, grid_iy, grid_iz) in, one noise_value (signed Q.16) out.
// Fully pipelined: one item per cycle sustained while no result is held by
// out_stall. Stages: index*spacing multiply; origin add and
// cell/fraction split; corner hash multiplies and fraction square; hash finish
// and fade cube/polynomial; fade weight multiply; then x, y and z lerps at two
// stages each (multiply, then add). The whole pipe advances together and
// holds while a result waits under out_stall, so in_stall follows out_stall
// only when the output register is full. Configuration writes are always
// accepted (cfg_ready tied high) and must only happen with the pipe empty.
module hashed_value_noise_3d_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  hvn_pkg::idx_t   grid_ix,
    input  hvn_pkg::idx_t   grid_iy,
    input  hvn_pkg::idx_t   grid_iz,
    output logic            out_valid,
    input  logic            out_stall,
    output hvn_pkg::noise_t noise_value,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  hvn_pkg::word_t  cfg_data
);
    import hvn_pkg::*;

    localparam int NUM_STAGES = 11;

    // configuration registers
    word_t origin_x_reg, origin_y_reg, origin_z_reg;
    word_t spacing_x_reg, spacing_y_reg, spacing_z_reg;
    word_t seed_reg;

    // pipeline valid bits, one per stage
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic                  en;

    hash_t   mx0, mx1, my0, my1, mz0, mz1;
    weight_t wu, wv, ww;
    noise_t  corner [8];
    noise_t  x00, x10, x01, x11, y0, y1, r;

    // y weight waits 2 stages, z weight 4 stages, for the lerps ahead of them
    weight_t wv_dly_reg [2];
    weight_t ww_dly_reg [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= ORIGIN_RESET;
            origin_y_reg  <= ORIGIN_RESET;
            origin_z_reg  <= ORIGIN_RESET;
            spacing_x_reg <= SPACING_RESET;
            spacing_y_reg <= SPACING_RESET;
            spacing_z_reg <= SPACING_RESET;
            seed_reg      <= SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:  origin_x_reg  <= cfg_data;
                REG_ORIGIN_Y:  origin_y_reg  <= cfg_data;
                REG_ORIGIN_Z:  origin_z_reg  <= cfg_data;
                REG_SPACING_X: spacing_x_reg <= cfg_data;
                REG_SPACING_Y: spacing_y_reg <= cfg_data;
                REG_SPACING_Z: spacing_z_reg <= cfg_data;
                REG_SEED:      seed_reg      <= cfg_data;
                default:       ; // unused index, write dropped
            endcase
        end
    end

    // global advance: hold everything only when the output item is blocked
    assign en         = !(valid_reg[NUM_STAGES-1] && out_stall);
    assign in_stall   = !en;
    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // stages 1-5 per axis
    hvn_axis u_axis_x (
        .clk      (clk),
        .en       (en),
        .g        (grid_ix),
        .origin   (origin_x_reg),
        .spacing  (spacing_x_reg),
        .hash_mul (HASH_MUL_A),
        .m0       (mx0),
        .m1       (mx1),
        .weight   (wu)
    );

    hvn_axis u_axis_y (
        .clk      (clk),
        .en       (en),
        .g        (grid_iy),
        .origin   (origin_y_reg),
        .spacing  (spacing_y_reg),
        .hash_mul (HASH_MUL_B),
        .m0       (my0),
        .m1       (my1),
        .weight   (wv)
    );

    hvn_axis u_axis_z (
        .clk      (clk),
        .en       (en),
        .g        (grid_iz),
        .origin   (origin_z_reg),
        .spacing  (spacing_z_reg),
        .hash_mul (HASH_MUL_C),
        .m0       (mz0),
        .m1       (mz1),
        .weight   (ww)
    );

    // stages 4-5: corner values, lined up with the weights
    hvn_corner u_corner (
        .clk    (clk),
        .en     (en),
        .seed   (seed_reg),
        .mx0    (mx0),
        .mx1    (mx1),
        .my0    (my0),
        .my1    (my1),
        .mz0    (mz0),
        .mz1    (mz1),
        .corner (corner)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wv_dly_reg[0] <= wv;
            wv_dly_reg[1] <= wv_dly_reg[0];
            ww_dly_reg[0] <= ww;
            ww_dly_reg[1] <= ww_dly_reg[0];
            ww_dly_reg[2] <= ww_dly_reg[1];
            ww_dly_reg[3] <= ww_dly_reg[2];
        end
    end

    // stages 6-7: along x
    hvn_lerp u_lerp_x00 (.clk(clk), .en(en), .a(corner[0]), .b(corner[1]), .w(wu), .res(x00));
    hvn_lerp u_lerp_x10 (.clk(clk), .en(en), .a(corner[2]), .b(corner[3]), .w(wu), .res(x10));
    hvn_lerp u_lerp_x01 (.clk(clk), .en(en), .a(corner[4]), .b(corner[5]), .w(wu), .res(x01));
    hvn_lerp u_lerp_x11 (.clk(clk), .en(en), .a(corner[6]), .b(corner[7]), .w(wu), .res(x11));

    // stages 8-9: along y
    hvn_lerp u_lerp_y0 (.clk(clk), .en(en), .a(x00), .b(x10), .w(wv_dly_reg[1]), .res(y0));
    hvn_lerp u_lerp_y1 (.clk(clk), .en(en), .a(x01), .b(x11), .w(wv_dly_reg[1]), .res(y1));

    // stages 10-11: along z; its result register is the output register
    hvn_lerp u_lerp_z (.clk(clk), .en(en), .a(y0), .b(y1), .w(ww_dly_reg[3]), .res(r));

    assign out_valid   = valid_reg[NUM_STAGES-1];
    assign noise_value = r;

endmodule

### verif/testbench.sv
// Self-checking testbench of the hashed 3D value-noise unit: directed and random grid points.
module testbench;
    import hvn_pkg::*;

    localparam int         PIPE_LATENCY = 11;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         LONG_HOLD    = 200;
    localparam int         PHASE_POINTS = 100;
    // index past the register list; the block must ignore it
    localparam logic [2:0] CFG_NO_REG   = 3'd7;

    // Expected noise samples in acceptance order, predicted from a private copy
    // of the registers.
    class noise_scoreboard;
        word_t  origin [3];
        word_t  spacing [3];
        word_t  seed;
        noise_t expected_noise [$];
        int     errors;

        function new();
            for (int k = 0; k < 3; k++)
            begin
                origin[k]  = ORIGIN_RESET;
                spacing[k] = SPACING_RESET;
            end
            seed   = SEED_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] index, word_t data);
            case (index)
                REG_ORIGIN_X:  origin[0]  = data;
                REG_ORIGIN_Y:  origin[1]  = data;
                REG_ORIGIN_Z:  origin[2]  = data;
                REG_SPACING_X: spacing[0] = data;
                REG_SPACING_Y: spacing[1] = data;
                REG_SPACING_Z: spacing[2] = data;
                REG_SEED:      seed       = data;
                default:       ;
            endcase
        endfunction

        // quintic fade of a Q0.16 fraction, every step floored
        function longint fade(frac_t t);
            longint tt, sq, inner, cube;
            tt    = t;
            sq    = (tt * tt) >> 16;
            inner = 6 * sq - 15 * tt + 10 * 65536;
            cube  = (sq * tt) >> 16;
            return (cube * inner) >> 16;
        endfunction

        // corner hash, centered to Q.9 and moved up to Q.16
        function longint corner(word_t a, word_t b, word_t c);
            word_t h;
            h = seed ^ (a * HASH_MUL_A) ^ (b * HASH_MUL_B) ^ (c * HASH_MUL_C);
            h = (h ^ (h >> 13)) * HASH_MUL_F;
            return (longint'(h[9:0]) - 512) * 128;
        endfunction

        function longint lerp(longint a, longint b, longint w);
            return a + ((w * (b - a)) >>> 16);
        endfunction

        function noise_t predict_noise(idx_t gx, idx_t gy, idx_t gz);
            idx_t   g [3];
            word_t  pos, lo [3], hi [3];
            longint wt [3];
            longint x00, x10, x01, x11, y0, y1, r;
            g = '{gx, gy, gz};
            for (int k = 0; k < 3; k++)
            begin
                pos   = origin[k] + word_t'(g[k]) * spacing[k];
                lo[k] = word_t'(pos[23:16]);
                hi[k] = lo[k] + 32'd1;      // far corner is not wrapped, may be 256
                wt[k] = fade(pos[15:0]);
            end
            x00 = lerp(corner(lo[0], lo[1], lo[2]), corner(hi[0], lo[1], lo[2]), wt[0]);
            x10 = lerp(corner(lo[0], hi[1], lo[2]), corner(hi[0], hi[1], lo[2]), wt[0]);
            x01 = lerp(corner(lo[0], lo[1], hi[2]), corner(hi[0], lo[1], hi[2]), wt[0]);
            x11 = lerp(corner(lo[0], hi[1], hi[2]), corner(hi[0], hi[1], hi[2]), wt[0]);
            y0  = lerp(x00, x10, wt[1]);
            y1  = lerp(x01, x11, wt[1]);
            r   = lerp(y0, y1, wt[2]);
            return r[16:0];
        endfunction

        function void note_point(idx_t gx, idx_t gy, idx_t gz);
            expected_noise.push_back(predict_noise(gx, gy, gz));
        endfunction

        function void check_sample(noise_t got);
            noise_t want;
            if (expected_noise.size() == 0)
            begin
                $error("noise_value: expected none, actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_noise.pop_front();
                if (got !== want)
                begin
                    $error("noise_value: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_noise.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    idx_t   grid_ix;
    idx_t   grid_iy;
    idx_t   grid_iz;
    logic   out_valid;
    logic   out_stall;
    noise_t noise_value;
    logic   cfg_valid;
    logic   cfg_ready;
    logic [2:0] cfg_index;
    word_t  cfg_data;

    noise_scoreboard noise_sb = new();
    int  cycle_count = 0;
    bit  quiet       = 0;    // no gaps and no stalls while set
    bit  hold_req    = 0;    // asks the receiver for one long hold-off

    hashed_value_noise_3d_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .grid_ix     (grid_ix),
        .grid_iy     (grid_iy),
        .grid_iz     (grid_iz),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Everything is sampled at the edge, before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                noise_sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                noise_sb.note_point(grid_ix, grid_iy, grid_iz);
            if (out_valid && !out_stall)
                noise_sb.check_sample(noise_value);
        end
    end

    // Receiver: short random stalls, rare long ones, none while quiet,
    // and one long hold-off on request so the pipe fills and backs up.
    initial
    begin
        int n;
        bit hold;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                hold     = 1;
                n        = LONG_HOLD;
            end
            else if (quiet)
            begin
                hold = 0;
                n    = 1;
            end
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 60)
                begin
                    hold = 0;
                    n    = $urandom_range(1, 8);
                end
                else if (n < 95)
                begin
                    hold = 1;
                    n    = $urandom_range(1, 3);
                end
                else
                begin
                    hold = 1;
                    n    = $urandom_range(10, 40);
                end
            end
            out_stall <= hold;
            if (hold && n == LONG_HOLD)
                repeat (n) @(posedge clk);
            else
                repeat (n)
                begin
                    @(posedge clk);
                    if (hold_req)
                        break;
                end
        end
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic idx_t pick_index();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return idx_t'(255 + $urandom_range(0, 1));
            default: return idx_t'($urandom_range(0, GRID_SIDE - 1));
        endcase
    endfunction

    // extremes, small signed steps with a fraction, or any word
    function automatic word_t pick_word();
        int    r;
        word_t v;
        r = $urandom_range(0, 9);
        case (r)
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h0000_0000;
            4, 5, 6:
            begin
                v = $urandom_range(0, 32'h0003_FFFF);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Called right after an edge; returns at the edge that takes the item.
    task automatic offer_point(idx_t gx, idx_t gy, idx_t gz, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        grid_ix  <= gx;
        grid_iy  <= gy;
        grid_iz  <= gz;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (noise_sb.pending() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] index, word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(word_t ox, word_t oy, word_t oz,
                           word_t sx, word_t sy, word_t sz, word_t sd);
        write_cfg(REG_ORIGIN_X,  ox);
        write_cfg(REG_ORIGIN_Y,  oy);
        write_cfg(REG_ORIGIN_Z,  oz);
        write_cfg(REG_SPACING_X, sx);
        write_cfg(REG_SPACING_Y, sy);
        write_cfg(REG_SPACING_Z, sz);
        write_cfg(REG_SEED,      sd);
    endtask

    initial
    begin
        int gap;
        bit burst;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        grid_ix   = '0;
        grid_iy   = '0;
        grid_iz   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: integer positions, cell 255 reaches far corner 256.
        offer_point(10'd0,   10'd0,   10'd0,    0);
        offer_point(10'd1023, 10'd1023, 10'd1023, 0);
        offer_point(10'd255, 10'd256, 10'd511,  1);
        offer_point(10'd682, 10'd341, 10'd1,    0);
        offer_point(10'd341, 10'd682, 10'd1022, 2);
        wait_for_results();

        // Extreme registers: positions overflow and go negative; stray index ignored.
        set_all(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h0000_8001, 32'h8000_0000, 32'hFFFF_FFFF);
        write_cfg(CFG_NO_REG, $urandom);
        offer_point(10'd0,    10'd0,    10'd0,    0);
        offer_point(10'd1023, 10'd1023, 10'd1023, 0);
        offer_point(10'd1,    10'd2,    10'd3,    0);
        offer_point(10'd512,  10'd1000, 10'd77,   3);
        wait_for_results();

        // Zero spacing: x fraction pinned at its maximum, y in cell 255.
        set_all(32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_8000,
                32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678);
        offer_point(10'd0,   10'd0,   10'd0,   0);
        offer_point(10'd5,   10'd700, 10'd999, 0);
        wait_for_results();

        // Fractional and negative steps walking across cells.
        set_all(32'hFFFF_8001, 32'h00FF_FFFF, 32'h8000_0001,
                32'h0000_4001, 32'hFFFF_C001, 32'h0101_0101, 32'h8000_0000);
        offer_point(10'd0,    10'd1023, 10'd0,    0);
        offer_point(10'd1023, 10'd0,    10'd1023, 0);
        offer_point(10'd3,    10'd5,    10'd7,    0);
        offer_point(10'd640,  10'd128,  10'd900,  1);
        wait_for_results();

        // Random phases, each with its own register set.
        for (int phase = 0; phase < 5; phase++)
        begin
            set_all(pick_word(), pick_word(), pick_word(),
                    pick_word(), pick_word(), pick_word(), $urandom);
            if (phase % 2 == 0)
                write_cfg(CFG_NO_REG, $urandom);
            for (int i = 0; i < PHASE_POINTS; i++)
            begin
                quiet = (i >= 30 && i < 50);
                burst = (phase == 1 && i >= 60);
                if (phase == 1 && i == 60)
                    hold_req = 1;
                if (phase == 2 && i == 60)
                    wait_for_results();
                gap = burst ? 0 : next_gap();
                offer_point(pick_index(), pick_index(), pick_index(), gap);
            end
            quiet = 0;
            wait_for_results();
        end

        if (noise_sb.errors == 0 && noise_sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
